FILE: rtl/dds_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the differential drive motion sequencer.
// No dependencies; every other file of the block imports this package.
package dds_pkg;

    // Field widths of the command and result beats.
    localparam int MODE_W   = 3;
    localparam int AMOUNT_W = 16;
    localparam int RAW_W    = 8;
    localparam int STEP_W   = 24;
    localparam int CAL_W    = 16;
    localparam int SLACK_W  = 8;
    localparam int VER_W    = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_CAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_CAL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLACK         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_VERSION    = 3'd5;

    // Register values after reset.
    localparam logic [CAL_W-1:0]   RST_STEPS_PER_MM  = 16'd256;
    localparam logic [CAL_W-1:0]   RST_STEPS_PER_DEG = 16'd256;
    localparam logic [CAL_W-1:0]   RST_MOVE_CAL      = 16'd16384;
    localparam logic [CAL_W-1:0]   RST_TURN_CAL      = 16'd16384;
    localparam logic [SLACK_W-1:0] RST_SLACK         = 8'd14;
    localparam logic [VER_W-1:0]   RST_HW_VERSION    = 2'd3;

    // Hardware revisions that steer when following a line.
    localparam logic [VER_W-1:0] VER_ONE = 2'd1;
    localparam logic [VER_W-1:0] VER_TWO = 2'd2;

    // Step scaling: amount (Q0) * per-unit (Q8.8) * calibration (Q2.14).
    localparam int PROD1_W  = 2 * AMOUNT_W;
    localparam int PROD_W   = PROD1_W + CAL_W;
    localparam int Q_SHIFT  = 22;
    localparam int STEP_BITS_DEF = 24;

    // Line follow deadband and automatic move amounts.
    localparam int DEADBAND = 5;
    localparam logic [AMOUNT_W-1:0] AMT_FOLLOW_FWD = 16'd5;
    localparam logic [AMOUNT_W-1:0] AMT_FOLLOW_TURN = 16'd1;
    localparam logic [AMOUNT_W-1:0] AMT_AVOID_BACK = 16'd50;
    localparam logic [AMOUNT_W-1:0] AMT_AVOID_TURN = 16'd90;
    localparam logic [AMOUNT_W-1:0] AMT_AVOID_FWD  = 16'd10;
    localparam logic [RAW_W-1:0]    BUMP_ON  = 8'hFF;
    localparam logic [RAW_W-1:0]    BUMP_OFF = 8'h00;

    // Result action codes.
    localparam logic ACT_TURN = 1'b0;
    localparam logic ACT_STOP = 1'b1;

    // Command queue depth.
    localparam int QDEPTH = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FWD    = 3'd0,
        MODE_BACK   = 3'd1,
        MODE_LEFT   = 3'd2,
        MODE_RIGHT  = 3'd3,
        MODE_STOP   = 3'd4,
        MODE_FOLLOW = 3'd5,
        MODE_AVOID  = 3'd6,
        MODE_TICK   = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        MV_FWD   = 2'd0,
        MV_BACK  = 2'd1,
        MV_LEFT  = 2'd2,
        MV_RIGHT = 2'd3
    } t_move;

    typedef enum logic {
        OP_MOVE = 1'b0,
        OP_STOP = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        AV_NORMAL     = 3'd0,
        AV_LEFT_REV   = 3'd1,
        AV_RIGHT_REV  = 3'd2,
        AV_LEFT_TURN  = 3'd3,
        AV_RIGHT_TURN = 3'd4
    } t_avoid;

    // One queued motion command, from the front to the back.
    typedef struct packed {
        t_op                 op;
        t_move               kind;
        logic [AMOUNT_W-1:0] amount;
    } t_cmd;

    // Configuration register file contents.
    typedef struct packed {
        logic [CAL_W-1:0]   steps_per_mm_q8;
        logic [CAL_W-1:0]   steps_per_degree_q8;
        logic [CAL_W-1:0]   move_cal_q14;
        logic [CAL_W-1:0]   turn_cal_q14;
        logic [SLACK_W-1:0] slack_steps;
        logic [VER_W-1:0]   hw_version;
    } t_cfg;

    // One result beat.
    typedef struct packed {
        logic              action;
        logic              motor_sel;
        logic              dir_forward;
        logic [STEP_W-1:0] step_count;
        logic              is_take_up;
        logic              last;
    } t_res;

endpackage

FILE: rtl/dds_in_if.sv
`timescale 1ns / 1ps
// Command channel of the motion sequencer: valid/ready plus the command fields.
// Depends on dds_pkg for the field widths.
interface dds_in_if import dds_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [AMOUNT_W-1:0] amount;
    logic [RAW_W-1:0]    line_left_raw;
    logic [RAW_W-1:0]    line_right_raw;
    logic [RAW_W-1:0]    bump_left_raw;
    logic [RAW_W-1:0]    bump_right_raw;
    logic                motors_idle;

    modport source (
        output valid, mode, amount, line_left_raw, line_right_raw,
               bump_left_raw, bump_right_raw, motors_idle,
        input  ready
    );
    modport sink (
        input  valid, mode, amount, line_left_raw, line_right_raw,
               bump_left_raw, bump_right_raw, motors_idle,
        output ready
    );
endinterface

FILE: rtl/dds_out_if.sv
`timescale 1ns / 1ps
// Motor command channel of the motion sequencer: valid/ready plus result fields.
// Depends on dds_pkg for the field widths.
interface dds_out_if import dds_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic              motor_sel;
    logic              dir_forward;
    logic [STEP_W-1:0] step_count;
    logic              is_take_up;
    logic              last;

    modport source (
        output valid, action, motor_sel, dir_forward, step_count, is_take_up, last,
        input  ready
    );
    modport sink (
        input  valid, action, motor_sel, dir_forward, step_count, is_take_up, last,
        output ready
    );
endinterface

FILE: rtl/dds_front.sv
`timescale 1ns / 1ps
// Front end: accepts command beats, tracks sensor readings and the automatic
// modes, and turns each beat into at most one queued motion command. Uses dds_pkg.
module dds_front import dds_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dds_in_if.sink        i_cmd,
    input  logic [VER_W-1:0] i_hw_version,
    input  logic          i_q_full,
    output logic          o_push,
    output t_cmd          o_push_cmd
);

    logic             r_follow_on, n_follow_on;
    logic             r_avoid_on, n_avoid_on;
    t_avoid           r_avoid_state, n_avoid_state;
    logic [RAW_W-1:0] r_line_left, n_line_left;
    logic [RAW_W-1:0] r_line_right, n_line_right;
    logic             r_bump_left, n_bump_left;
    logic             r_bump_right, n_bump_right;

    logic              accept;
    logic              reading_ok;
    logic              tick_latch;
    logic signed [RAW_W:0] diff;

    // A beat is taken whenever the command queue has room.
    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Bump bytes are only trusted when both sit at a rail.
    assign reading_ok = (i_cmd.bump_left_raw == BUMP_OFF || i_cmd.bump_left_raw == BUMP_ON) &&
                        (i_cmd.bump_right_raw == BUMP_OFF || i_cmd.bump_right_raw == BUMP_ON);

    // A tick with clean bump bytes latches all four readings.
    assign tick_latch   = accept && (t_mode'(i_cmd.mode) == MODE_TICK) && reading_ok;
    assign n_line_left  = tick_latch ? i_cmd.line_left_raw : r_line_left;
    assign n_line_right = tick_latch ? i_cmd.line_right_raw : r_line_right;
    assign n_bump_left  = tick_latch ? (i_cmd.bump_left_raw != BUMP_OFF) : r_bump_left;
    assign n_bump_right = tick_latch ? (i_cmd.bump_right_raw != BUMP_OFF) : r_bump_right;

    // Steering error from the readings as they stand after this tick.
    assign diff = $signed({1'b0, n_line_left}) - $signed({1'b0, n_line_right});

    // Classify the beat and work out the next mode state.
    always_comb begin
        n_follow_on   = r_follow_on;
        n_avoid_on    = r_avoid_on;
        n_avoid_state = r_avoid_state;
        o_push        = 1'b0;
        o_push_cmd    = '{op: OP_MOVE, kind: MV_FWD, amount: '0};

        if (accept) begin
            case (t_mode'(i_cmd.mode))
                MODE_FWD, MODE_BACK, MODE_LEFT, MODE_RIGHT: begin
                    o_push            = 1'b1;
                    o_push_cmd.kind   = t_move'(i_cmd.mode[1:0]);
                    o_push_cmd.amount = i_cmd.amount;
                end
                MODE_STOP: begin
                    o_push        = 1'b1;
                    o_push_cmd.op = OP_STOP;
                    n_follow_on   = 1'b0;
                    n_avoid_on    = 1'b0;
                end
                MODE_FOLLOW: begin
                    n_follow_on = 1'b1;
                end
                MODE_AVOID: begin
                    n_avoid_on = 1'b1;
                end
                MODE_TICK: begin
                    if (r_follow_on) begin
                        // Line following only steps once the wheels are at rest.
                        if (i_cmd.motors_idle) begin
                            if (diff > (RAW_W+1)'(DEADBAND)) begin
                                o_push_cmd.amount = AMT_FOLLOW_TURN;
                                if (i_hw_version == VER_ONE) begin
                                    o_push          = 1'b1;
                                    o_push_cmd.kind = MV_RIGHT;
                                end else if (i_hw_version == VER_TWO) begin
                                    o_push          = 1'b1;
                                    o_push_cmd.kind = MV_LEFT;
                                end
                            end else if (diff < -(RAW_W+1)'(DEADBAND)) begin
                                o_push_cmd.amount = AMT_FOLLOW_TURN;
                                if (i_hw_version == VER_ONE) begin
                                    o_push          = 1'b1;
                                    o_push_cmd.kind = MV_LEFT;
                                end else if (i_hw_version == VER_TWO) begin
                                    o_push          = 1'b1;
                                    o_push_cmd.kind = MV_RIGHT;
                                end
                            end else begin
                                o_push            = 1'b1;
                                o_push_cmd.kind   = MV_FWD;
                                o_push_cmd.amount = AMT_FOLLOW_FWD;
                            end
                        end
                    end else if (r_avoid_on) begin
                        if (r_avoid_state == AV_NORMAL) begin
                            o_push = 1'b1;
                            if (n_bump_left) begin
                                n_avoid_state     = AV_LEFT_REV;
                                o_push_cmd.kind   = MV_BACK;
                                o_push_cmd.amount = AMT_AVOID_BACK;
                            end else if (n_bump_right) begin
                                n_avoid_state     = AV_RIGHT_REV;
                                o_push_cmd.kind   = MV_BACK;
                                o_push_cmd.amount = AMT_AVOID_BACK;
                            end else begin
                                o_push_cmd.kind   = MV_FWD;
                                o_push_cmd.amount = AMT_AVOID_FWD;
                            end
                        end else if (i_cmd.motors_idle) begin
                            // Reverse done: turn away from the bump, then resume.
                            case (r_avoid_state)
                                AV_LEFT_REV: begin
                                    n_avoid_state     = AV_LEFT_TURN;
                                    o_push            = 1'b1;
                                    o_push_cmd.kind   = MV_RIGHT;
                                    o_push_cmd.amount = AMT_AVOID_TURN;
                                end
                                AV_RIGHT_REV: begin
                                    n_avoid_state     = AV_RIGHT_TURN;
                                    o_push            = 1'b1;
                                    o_push_cmd.kind   = MV_LEFT;
                                    o_push_cmd.amount = AMT_AVOID_TURN;
                                end
                                default: begin
                                    n_avoid_state = AV_NORMAL;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Mode flags and latched readings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow_on   <= 1'b0;
            r_avoid_on    <= 1'b0;
            r_avoid_state <= AV_NORMAL;
            r_line_left   <= '0;
            r_line_right  <= '0;
            r_bump_left   <= 1'b0;
            r_bump_right  <= 1'b0;
        end else begin
            r_follow_on   <= n_follow_on;
            r_avoid_on    <= n_avoid_on;
            r_avoid_state <= n_avoid_state;
            r_line_left   <= n_line_left;
            r_line_right  <= n_line_right;
            r_bump_left   <= n_bump_left;
            r_bump_right  <= n_bump_right;
        end
    end

    // A stop beat leaves both automatic modes off.
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_mode'(i_cmd.mode) == MODE_STOP) |=> (!r_follow_on && !r_avoid_on))
        else $error("automatic mode still on after stop");

    // Nothing is queued unless a beat was taken.
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("command queued without an accepted beat");

    // Readings only change on a tick beat.
    a_readings_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && t_mode'(i_cmd.mode) == MODE_TICK) |=>
            ($stable(r_line_left) && $stable(r_line_right)))
        else $error("line readings changed outside a tick");

endmodule

FILE: rtl/dds_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the motor sequencer.
// Uses dds_pkg for the command type and depth.
module dds_queue import dds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int IDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [IDX_W-1:0] r_wp, n_wp;
    logic [IDX_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    // Pointer and fill count update with wrap at the depth.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == IDX_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == IDX_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty command queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("command queue count past depth");

endmodule

FILE: rtl/dds_back.sv
`timescale 1ns / 1ps
// Back end: takes queued motion commands, scales the step count in a two-stage
// multiply and issues take-up, main or stop beats per wheel. Uses dds_pkg, dds_out_if.
module dds_back import dds_pkg::*; #(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_cmd    i_q_head,
    output logic    o_q_pop,
    dds_out_if.source o_res
);

    localparam int SCALED_W = PROD_W - Q_SHIFT;
    localparam int SAT_W    = 33;
    localparam logic [SAT_W-1:0] STEP_MAX = (SAT_W'(1) << STEP_BITS) - SAT_W'(1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_EMIT
    } t_bstate;

    t_bstate              r_state;
    t_op                  r_op;
    logic                 r_dir_a, r_dir_b;
    logic                 r_last_dir_first, r_last_dir_second;
    logic [3:0]           r_pend;
    logic [PROD1_W-1:0]   r_prod1;
    logic [CAL_W-1:0]     r_cal;
    logic [PROD_W-1:0]    r_prod2;
    logic                 r_out_valid;
    t_res                 r_out;

    logic                 dir_a, dir_b, is_turn;
    logic [CAL_W-1:0]     per_unit, cal_sel;
    logic [3:0]           sel_oh, rest;
    logic [SCALED_W-1:0]  scaled;
    logic [SAT_W-1:0]     scaled_ext, steps_sat;
    logic                 slot_free;
    logic                 issue;
    t_res                 beat;

    // Wheel directions: the first wheel runs forward on fwd and left, the
    // mirrored second wheel on back and left.
    assign dir_a   = !i_q_head.kind[0];
    assign dir_b   = i_q_head.kind[0] ^ i_q_head.kind[1];
    assign is_turn = (i_q_head.kind == MV_LEFT) || (i_q_head.kind == MV_RIGHT);
    assign per_unit = is_turn ? i_cfg.steps_per_degree_q8 : i_cfg.steps_per_mm_q8;
    assign cal_sel  = is_turn ? i_cfg.turn_cal_q14 : i_cfg.move_cal_q14;

    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign slot_free = !r_out_valid || o_res.ready;
    assign issue     = (r_state == B_EMIT) && slot_free;

    // Truncate the product and saturate to the step range.
    assign scaled     = r_prod2[PROD_W-1:Q_SHIFT];
    assign scaled_ext = SAT_W'(scaled);
    assign steps_sat  = (scaled_ext > STEP_MAX) ? STEP_MAX : scaled_ext;

    // Pending beats in order: take-up first, take-up second, main first,
    // main second. The lowest pending one goes out next.
    always_comb begin
        sel_oh = r_pend & (~r_pend + 4'd1);
        rest   = r_pend & ~sel_oh;
        beat.action      = (r_op == OP_STOP) ? ACT_STOP : ACT_TURN;
        beat.motor_sel   = sel_oh[1] | sel_oh[3];
        beat.is_take_up  = (r_op == OP_MOVE) && (sel_oh[0] | sel_oh[1]);
        beat.last        = (rest == '0);
        if (r_op == OP_STOP) begin
            beat.dir_forward = 1'b0;
            beat.step_count  = '0;
        end else begin
            beat.dir_forward = (sel_oh[0] | sel_oh[2]) ? r_dir_a : r_dir_b;
            beat.step_count  = (sel_oh[0] | sel_oh[1]) ? STEP_W'(i_cfg.slack_steps)
                                                       : steps_sat[STEP_W-1:0];
        end
    end

    // Sequencer state, multiply stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= B_IDLE;
            r_pend            <= '0;
            r_last_dir_first  <= 1'b1;
            r_last_dir_second <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            // The output register fills on an issue and empties when taken.
            r_out_valid <= issue || (r_out_valid && !o_res.ready);
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_op <= i_q_head.op;
                        if (i_q_head.op == OP_STOP) begin
                            r_pend  <= 4'b1100;
                            r_state <= B_EMIT;
                        end else begin
                            r_dir_a  <= dir_a;
                            r_dir_b  <= dir_b;
                            r_pend   <= {2'b11, (r_last_dir_second != dir_b),
                                         (r_last_dir_first != dir_a)};
                            r_last_dir_first  <= dir_a;
                            r_last_dir_second <= dir_b;
                            r_prod1  <= PROD1_W'(i_q_head.amount) * PROD1_W'(per_unit);
                            r_cal    <= cal_sel;
                            r_state  <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    r_prod2 <= PROD_W'(r_prod1) * PROD_W'(r_cal);
                    r_state <= B_EMIT;
                end
                B_EMIT: begin
                    if (slot_free) begin
                        r_out  <= beat;
                        r_pend <= rest;
                        if (rest == '0) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_out.action;
    assign o_res.motor_sel   = r_out.motor_sel;
    assign o_res.dir_forward = r_out.dir_forward;
    assign o_res.step_count  = r_out.step_count;
    assign o_res.is_take_up  = r_out.is_take_up;
    assign o_res.last        = r_out.last;

    a_mul_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL) |=> (r_state == B_EMIT))
        else $error("multiply stage did not hand over to issue");

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_pend != '0))
        else $error("issuing with no pending beat");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (r_pend == '0))
        else $error("pending beats left behind");

    a_stop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_STOP) |->
            (r_out.step_count == '0 && !r_out.is_take_up && !r_out.dir_forward))
        else $error("stop beat with motion fields set");

endmodule

FILE: rtl/diff_drive_motion_sequencer.sv
`timescale 1ns / 1ps
// Top level of the two-wheel stepper motion sequencer: configuration registers,
// front end, command queue and motor sequencer. Uses dds_pkg, dds_in_if, dds_out_if.
//
//  Port        | Dir | Handshake        | Carries
//  ------------+-----+------------------+--------------------------------------
//  i_cmd       | in  | valid/ready      | mode, amount, sensor bytes, idle flag
//  o_res       | out | valid/ready      | motor command: action, wheel, steps
//  i_cfg_*     | in  | write enable     | register index and 16-bit value
//
// A move gives 2 to 4 motor commands: the sequencer pops it and forms the first
// partial product, does the second multiply, then issues each motor command
// through the output register. A stop gives a stop command to each wheel; flag
// and tick beats that move nothing stay in the front end. The front end keeps
// taking beats while the two-entry queue has room, and the output register
// holds a beat until it is taken. Reset is synchronous and active low.
module diff_drive_motion_sequencer import dds_pkg::*; #(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dds_in_if.sink                i_cmd,
    dds_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_push_cmd, q_head;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_mm_q8     <= RST_STEPS_PER_MM;
            r_cfg.steps_per_degree_q8 <= RST_STEPS_PER_DEG;
            r_cfg.move_cal_q14        <= RST_MOVE_CAL;
            r_cfg.turn_cal_q14        <= RST_TURN_CAL;
            r_cfg.slack_steps         <= RST_SLACK;
            r_cfg.hw_version          <= RST_HW_VERSION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEPS_PER_MM:  r_cfg.steps_per_mm_q8     <= i_cfg_data;
                CFG_STEPS_PER_DEG: r_cfg.steps_per_degree_q8 <= i_cfg_data;
                CFG_MOVE_CAL:      r_cfg.move_cal_q14        <= i_cfg_data;
                CFG_TURN_CAL:      r_cfg.turn_cal_q14        <= i_cfg_data;
                CFG_SLACK:         r_cfg.slack_steps         <= i_cfg_data[SLACK_W-1:0];
                CFG_HW_VERSION:    r_cfg.hw_version          <= i_cfg_data[VER_W-1:0];
                default: ;
            endcase
        end
    end

    dds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_hw_version (r_cfg.hw_version),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_cmd   (q_push_cmd)
    );

    dds_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    dds_back #(
        .STEP_BITS (STEP_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for diff_drive_motion_sequencer: random-gap command beats, a
// predictor of every motor command beat and an in-order scoreboard.
// Depends on dds_pkg, dds_in_if, dds_out_if and the sequencer RTL.
module tb_top;
    import dds_pkg::*;

    // Cycles of quiet after the last expected beat before the block counts as idle.
    localparam int SETTLE      = 16;
    localparam int QUIET_LIMIT = 1000;
    localparam int PRINT_CAP   = 40;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 14;

    localparam logic WHEEL_FIRST  = 1'b0;
    localparam logic WHEEL_SECOND = 1'b1;
    localparam logic DIR_FWD      = 1'b1;
    localparam logic DIR_BACK     = 1'b0;

    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_CFG,
        STEP_SYNC
    } t_step_kind;

    // One entry of the stimulus plan: a command beat, a register write or a drain.
    typedef struct {
        t_step_kind            kind;
        t_mode                 mode;
        logic [AMOUNT_W-1:0]   amount;
        logic [RAW_W-1:0]      line_l;
        logic [RAW_W-1:0]      line_r;
        logic [RAW_W-1:0]      bump_l;
        logic [RAW_W-1:0]      bump_r;
        logic                  idle;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
    } t_plan_entry;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dds_in_if  cmd_if ();
    dds_out_if res_if ();

    diff_drive_motion_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Stimulus plan and bench bookkeeping.
    t_plan_entry plan_q[$];
    t_res        motor_cmds_due[$];
    logic        drained   = 1'b1;
    logic        feed_done = 1'b0;
    logic        send_calm = 1'b0;
    logic        take_calm = 1'b0;
    int          send_gap  = 0;
    int          take_gap  = 0;
    int          sync_cnt  = 0;
    int          quiet_cycles = 0;
    int          planned_beats = 0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          mismatches = 0;

    // Predictor copy of the registers and the sequencer state.
    t_cfg        cfg_now;
    logic        dir_first;
    logic        dir_second;
    t_avoid      avoid_phase;
    logic        follow_en;
    logic        avoid_en;
    logic [RAW_W-1:0] line_l;
    logic [RAW_W-1:0] line_r;
    logic        bump_l;
    logic        bump_r;

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Steps for a move: amount (Q0) times per-unit (Q8.8) times calibration (Q2.14),
    // truncated and saturated to the step field.
    function automatic logic [STEP_W-1:0] scaled_steps(input logic [AMOUNT_W-1:0] amt,
                                                       input logic [CAL_W-1:0] per_unit,
                                                       input logic [CAL_W-1:0] cal);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(amt) * PROD_W'(per_unit) * PROD_W'(cal);
        prod = prod >> Q_SHIFT;
        return (prod > PROD_W'({STEP_W{1'b1}})) ? {STEP_W{1'b1}} : prod[STEP_W-1:0];
    endfunction

    task automatic push_motor_cmd(input logic action, input logic sel, input logic fwd,
                                  input logic [STEP_W-1:0] steps, input logic take_up);
        t_res r;
        r.action      = action;
        r.motor_sel   = sel;
        r.dir_forward = fwd;
        r.step_count  = steps;
        r.is_take_up  = take_up;
        r.last        = 1'b0;
        motor_cmds_due.push_back(r);
    endtask

    // Take-up moves for wheels that reverse, then both main moves.
    task automatic predict_move(input t_move kind, input logic [AMOUNT_W-1:0] amt);
        logic                a;
        logic                b;
        logic [STEP_W-1:0]   steps;
        case (kind)
            MV_FWD: begin
                a = DIR_FWD;
                b = DIR_BACK;
            end
            MV_BACK: begin
                a = DIR_BACK;
                b = DIR_FWD;
            end
            MV_LEFT: begin
                a = DIR_FWD;
                b = DIR_FWD;
            end
            default: begin
                a = DIR_BACK;
                b = DIR_BACK;
            end
        endcase
        if (kind == MV_LEFT || kind == MV_RIGHT)
            steps = scaled_steps(amt, cfg_now.steps_per_degree_q8, cfg_now.turn_cal_q14);
        else
            steps = scaled_steps(amt, cfg_now.steps_per_mm_q8, cfg_now.move_cal_q14);
        if (dir_first != a)
            push_motor_cmd(ACT_TURN, WHEEL_FIRST, a, STEP_W'(cfg_now.slack_steps), 1'b1);
        if (dir_second != b)
            push_motor_cmd(ACT_TURN, WHEEL_SECOND, b, STEP_W'(cfg_now.slack_steps), 1'b1);
        push_motor_cmd(ACT_TURN, WHEEL_FIRST, a, steps, 1'b0);
        push_motor_cmd(ACT_TURN, WHEEL_SECOND, b, steps, 1'b0);
        dir_first  = a;
        dir_second = b;
    endtask

    // Line following: steer only when the motors are idle, sense set by the version.
    task automatic predict_follow(input logic idle);
        int diff;
        diff = int'(line_l) - int'(line_r);
        if (idle) begin
            if (diff > DEADBAND) begin
                if (cfg_now.hw_version == VER_ONE)
                    predict_move(MV_RIGHT, AMT_FOLLOW_TURN);
                else if (cfg_now.hw_version == VER_TWO)
                    predict_move(MV_LEFT, AMT_FOLLOW_TURN);
            end else if (diff < -DEADBAND) begin
                if (cfg_now.hw_version == VER_ONE)
                    predict_move(MV_LEFT, AMT_FOLLOW_TURN);
                else if (cfg_now.hw_version == VER_TWO)
                    predict_move(MV_RIGHT, AMT_FOLLOW_TURN);
            end else begin
                predict_move(MV_FWD, AMT_FOLLOW_FWD);
            end
        end
    endtask

    // Bump avoidance: back off on a bump, then turn away once the motors settle.
    task automatic predict_avoid(input logic idle);
        if (avoid_phase == AV_NORMAL) begin
            if (bump_l) begin
                avoid_phase = AV_LEFT_REV;
                predict_move(MV_BACK, AMT_AVOID_BACK);
            end else if (bump_r) begin
                avoid_phase = AV_RIGHT_REV;
                predict_move(MV_BACK, AMT_AVOID_BACK);
            end else begin
                predict_move(MV_FWD, AMT_AVOID_FWD);
            end
        end else if (idle) begin
            if (avoid_phase == AV_LEFT_REV) begin
                avoid_phase = AV_LEFT_TURN;
                predict_move(MV_RIGHT, AMT_AVOID_TURN);
            end else if (avoid_phase == AV_RIGHT_REV) begin
                avoid_phase = AV_RIGHT_TURN;
                predict_move(MV_LEFT, AMT_AVOID_TURN);
            end else begin
                avoid_phase = AV_NORMAL;
            end
        end
    endtask

    // Expected motor command beats for one accepted command beat.
    task automatic predict_motor_cmds(input t_plan_entry beat);
        int   first_new;
        t_res tail;
        first_new = motor_cmds_due.size();
        case (beat.mode)
            MODE_FWD, MODE_BACK, MODE_LEFT, MODE_RIGHT: begin
                predict_move(t_move'(beat.mode[1:0]), beat.amount);
            end
            MODE_STOP: begin
                push_motor_cmd(ACT_STOP, WHEEL_FIRST, 1'b0, '0, 1'b0);
                push_motor_cmd(ACT_STOP, WHEEL_SECOND, 1'b0, '0, 1'b0);
                follow_en = 1'b0;
                avoid_en  = 1'b0;
            end
            MODE_FOLLOW: follow_en = 1'b1;
            MODE_AVOID:  avoid_en  = 1'b1;
            default: begin
                // Readings latch only when both bump bytes are clean.
                if ((beat.bump_l == BUMP_OFF || beat.bump_l == BUMP_ON) &&
                    (beat.bump_r == BUMP_OFF || beat.bump_r == BUMP_ON)) begin
                    line_l = beat.line_l;
                    line_r = beat.line_r;
                    bump_l = (beat.bump_l != BUMP_OFF);
                    bump_r = (beat.bump_r != BUMP_OFF);
                end
                if (follow_en)
                    predict_follow(beat.idle);
                else if (avoid_en)
                    predict_avoid(beat.idle);
            end
        endcase
        if (motor_cmds_due.size() > first_new) begin
            tail = motor_cmds_due.pop_back();
            tail.last = 1'b1;
            motor_cmds_due.push_back(tail);
        end
    endtask

    // Plan builders.
    task automatic add_beat(input t_mode mode, input logic [AMOUNT_W-1:0] amt,
                            input logic [RAW_W-1:0] ll, input logic [RAW_W-1:0] lr,
                            input logic [RAW_W-1:0] bl, input logic [RAW_W-1:0] br,
                            input logic idle);
        t_plan_entry e;
        e.kind     = STEP_BEAT;
        e.mode     = mode;
        e.amount   = amt;
        e.line_l   = ll;
        e.line_r   = lr;
        e.bump_l   = bl;
        e.bump_r   = br;
        e.idle     = idle;
        e.cfg_idx  = CFG_STEPS_PER_MM;
        e.cfg_data = '0;
        plan_q.push_back(e);
        planned_beats++;
    endtask

    task automatic add_sync();
        t_plan_entry e;
        e.kind     = STEP_SYNC;
        e.mode     = MODE_STOP;
        e.amount   = '0;
        e.line_l   = '0;
        e.line_r   = '0;
        e.bump_l   = '0;
        e.bump_r   = '0;
        e.idle     = 1'b0;
        e.cfg_idx  = CFG_STEPS_PER_MM;
        e.cfg_data = '0;
        plan_q.push_back(e);
    endtask

    // Drain the block, then write all six registers.
    task automatic add_settings(input logic [CAL_W-1:0] mm, input logic [CAL_W-1:0] deg,
                                input logic [CAL_W-1:0] mcal, input logic [CAL_W-1:0] tcal,
                                input logic [SLACK_W-1:0] slack,
                                input logic [VER_W-1:0] ver);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] vals [6];
        t_plan_entry           e;
        idx  = '{CFG_STEPS_PER_MM, CFG_STEPS_PER_DEG, CFG_MOVE_CAL, CFG_TURN_CAL,
                 CFG_SLACK, CFG_HW_VERSION};
        vals = '{mm, deg, mcal, tcal, CFG_DATA_W'(slack), CFG_DATA_W'(ver)};
        add_sync();
        e = plan_q[$];
        e.kind = STEP_CFG;
        for (int i = 0; i < 6; i++) begin
            e.cfg_idx  = idx[i];
            e.cfg_data = vals[i];
            plan_q.push_back(e);
        end
    endtask

    // Mostly clean bump bytes, with a few corrupt ones.
    function automatic logic [RAW_W-1:0] rand_bump();
        int p;
        p = $urandom_range(0, 19);
        if (p < 5)
            return BUMP_ON;
        else if (p < 18)
            return BUMP_OFF;
        return RAW_W'($urandom_range(1, 254));
    endfunction

    function automatic logic [AMOUNT_W-1:0] rand_amount();
        if ($urandom_range(0, 1) == 0)
            return AMOUNT_W'($urandom_range(0, 65535));
        return AMOUNT_W'($urandom_range(0, 300));
    endfunction

    // Driver: feeds command beats and register writes from the plan.
    always @(posedge i_clk) begin : driver
        t_plan_entry nxt;
        logic        nxt_valid;
        logic        nxt_we;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            i_cfg_we     <= 1'b0;
            feed_done    <= 1'b0;
            send_gap = 0;
            sync_cnt = 0;
        end else begin
            nxt_valid = cmd_if.valid;
            nxt_we    = 1'b0;
            if (cmd_if.valid && cmd_if.ready) begin
                nxt_valid = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 15);
            end
            if (!nxt_valid && plan_q.size() != 0) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else begin
                    nxt = plan_q[0];
                    case (nxt.kind)
                        STEP_BEAT: begin
                            cmd_if.mode           <= nxt.mode;
                            cmd_if.amount         <= nxt.amount;
                            cmd_if.line_left_raw  <= nxt.line_l;
                            cmd_if.line_right_raw <= nxt.line_r;
                            cmd_if.bump_left_raw  <= nxt.bump_l;
                            cmd_if.bump_right_raw <= nxt.bump_r;
                            cmd_if.motors_idle    <= nxt.idle;
                            nxt_valid = 1'b1;
                            void'(plan_q.pop_front());
                        end
                        STEP_CFG: begin
                            i_cfg_idx  <= nxt.cfg_idx;
                            i_cfg_data <= nxt.cfg_data;
                            nxt_we = 1'b1;
                            void'(plan_q.pop_front());
                        end
                        default: begin
                            // Hold off until every expected beat is back and the block settles.
                            sync_cnt = drained ? sync_cnt + 1 : 0;
                            if (sync_cnt >= SETTLE) begin
                                sync_cnt = 0;
                                void'(plan_q.pop_front());
                            end
                        end
                    endcase
                end
            end
            cmd_if.valid <= nxt_valid;
            i_cfg_we     <= nxt_we;
            feed_done    <= (plan_q.size() == 0) && !nxt_valid;
        end
    end

    // Result side: random stalls per beat, with calm stretches.
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if ($urandom_range(0, 15) == 0)
                    take_calm = !take_calm;
                take_gap = take_calm ? 0 : $urandom_range(0, 15);
            end
            if (take_gap != 0) begin
                take_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: tracks register writes, predicts on accepted commands, checks results.
    always @(posedge i_clk) begin : monitor
        t_plan_entry beat;
        t_res        got;
        t_res        want;
        if (!i_rst_n) begin
            cfg_now.steps_per_mm_q8     = RST_STEPS_PER_MM;
            cfg_now.steps_per_degree_q8 = RST_STEPS_PER_DEG;
            cfg_now.move_cal_q14        = RST_MOVE_CAL;
            cfg_now.turn_cal_q14        = RST_TURN_CAL;
            cfg_now.slack_steps         = RST_SLACK;
            cfg_now.hw_version          = RST_HW_VERSION;
            dir_first   = DIR_FWD;
            dir_second  = DIR_FWD;
            avoid_phase = AV_NORMAL;
            follow_en   = 1'b0;
            avoid_en    = 1'b0;
            line_l      = '0;
            line_r      = '0;
            bump_l      = 1'b0;
            bump_r      = 1'b0;
            motor_cmds_due.delete();
            drained <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                cfg_writes++;
                case (i_cfg_idx)
                    CFG_STEPS_PER_MM:  cfg_now.steps_per_mm_q8     = i_cfg_data;
                    CFG_STEPS_PER_DEG: cfg_now.steps_per_degree_q8 = i_cfg_data;
                    CFG_MOVE_CAL:      cfg_now.move_cal_q14        = i_cfg_data;
                    CFG_TURN_CAL:      cfg_now.turn_cal_q14        = i_cfg_data;
                    CFG_SLACK:         cfg_now.slack_steps         = i_cfg_data[SLACK_W-1:0];
                    CFG_HW_VERSION:    cfg_now.hw_version          = i_cfg_data[VER_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_if.valid && cmd_if.ready) begin
                beat.kind   = STEP_BEAT;
                beat.mode   = t_mode'(cmd_if.mode);
                beat.amount = cmd_if.amount;
                beat.line_l = cmd_if.line_left_raw;
                beat.line_r = cmd_if.line_right_raw;
                beat.bump_l = cmd_if.bump_left_raw;
                beat.bump_r = cmd_if.bump_right_raw;
                beat.idle   = cmd_if.motors_idle;
                predict_motor_cmds(beat);
                beats_sent++;
            end
            if (res_if.valid && res_if.ready) begin
                got.action      = res_if.action;
                got.motor_sel   = res_if.motor_sel;
                got.dir_forward = res_if.dir_forward;
                got.step_count  = res_if.step_count;
                got.is_take_up  = res_if.is_take_up;
                got.last        = res_if.last;
                results_seen++;
                if (motor_cmds_due.size() == 0) begin
                    note_mismatch("unexpected motor command", 32'(got), '0);
                end else begin
                    want = motor_cmds_due.pop_front();
                    if (got.action !== want.action)
                        note_mismatch("action", 32'(got.action), 32'(want.action));
                    if (got.motor_sel !== want.motor_sel)
                        note_mismatch("motor_sel", 32'(got.motor_sel), 32'(want.motor_sel));
                    if (got.dir_forward !== want.dir_forward)
                        note_mismatch("dir_forward", 32'(got.dir_forward),
                                      32'(want.dir_forward));
                    if (got.step_count !== want.step_count)
                        note_mismatch("step_count", 32'(got.step_count),
                                      32'(want.step_count));
                    if (got.is_take_up !== want.is_take_up)
                        note_mismatch("is_take_up", 32'(got.is_take_up),
                                      32'(want.is_take_up));
                    if (got.last !== want.last)
                        note_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end
            drained <= (motor_cmds_due.size() == 0);
        end
    end

    // Watchdog: ends a run that stops making progress.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin : stimulus
        int          target;
        int          pick;
        int          ll_i;
        int          lr_i;
        logic [1:0]  ver;
        cmd_if.valid          = 1'b0;
        cmd_if.mode           = MODE_FWD;
        cmd_if.amount         = '0;
        cmd_if.line_left_raw  = '0;
        cmd_if.line_right_raw = '0;
        cmd_if.bump_left_raw  = '0;
        cmd_if.bump_right_raw = '0;
        cmd_if.motors_idle    = 1'b0;
        res_if.ready          = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_STEPS_PER_MM;
        i_cfg_data            = '0;
        i_rst_n               = 1'b0;

        // Directed part at reset settings (version 3 goes straight only).
        // Zero-step move, full-range moves, take-ups on one or both wheels, stop.
        add_beat(MODE_FWD,   16'd0,     8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_FWD,   16'hFFFF,  8'hFF, 8'hFF, BUMP_ON,  BUMP_ON,  1'b0);
        add_beat(MODE_BACK,  16'd1,     8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_LEFT,  16'd90,    8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_RIGHT, 16'hFFFF,  8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_STOP,  16'hA5A5,  8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        // A tick with no auto mode only latches readings.
        add_beat(MODE_TICK,  16'd0,     8'hFF, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        // Line following: waits for idle motors, deadband edges, no steering on version 3.
        add_beat(MODE_FOLLOW, 16'd0,    8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'd128, 8'd128, BUMP_OFF, BUMP_OFF, 1'b0);
        add_beat(MODE_TICK,  16'd0,     8'd128, 8'd128, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'd133, 8'd128, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'd122, 8'd128, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'hFF, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        // A corrupt bump byte keeps the old readings, so this must not go straight.
        add_beat(MODE_TICK,  16'd0,     8'h00, 8'h00, 8'h01,    BUMP_OFF, 1'b1);
        add_beat(MODE_STOP,  16'd0,     8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        // Bump avoidance through both reverse-turn branches.
        add_beat(MODE_AVOID, 16'd0,     8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b0);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_ON,  BUMP_OFF, 1'b0);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_OFF, BUMP_ON,  1'b0);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'h10, 8'h10, BUMP_ON,  BUMP_ON,  1'b0);
        // Following wins over avoidance when both are on.
        add_beat(MODE_FOLLOW, 16'd0,    8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_TICK,  16'd0,     8'h40, 8'h40, BUMP_OFF, BUMP_OFF, 1'b1);
        add_beat(MODE_STOP,  16'd0,     8'h00, 8'h00, BUMP_OFF, BUMP_OFF, 1'b1);

        // Random part over several register settings, extremes first.
        for (int phase = 0; phase < PHASES; phase++) begin
            ver = VER_W'($urandom_range(1, 3));
            case (phase)
                0: add_settings('1, '1, '1, '1, '1, VER_ONE);
                1: add_settings('0, '0, '0, '0, '0, VER_TWO);
                2: add_settings(CAL_W'($urandom_range(0, 65535)),
                                CAL_W'($urandom_range(0, 65535)),
                                CAL_W'($urandom_range(0, 65535)),
                                CAL_W'($urandom_range(0, 65535)),
                                SLACK_W'($urandom_range(0, 255)), RST_HW_VERSION);
                default: add_settings(CAL_W'($urandom_range(0, 1024)),
                                      CAL_W'($urandom_range(0, 1024)),
                                      CAL_W'($urandom_range(0, 32768)),
                                      CAL_W'($urandom_range(0, 32768)),
                                      SLACK_W'($urandom_range(0, 255)), ver);
            endcase
            target = planned_beats + PHASE_BEATS;
            while (planned_beats < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    // Plain move with random amount; unused fields random.
                    add_beat(t_mode'(MODE_W'($urandom_range(0, 3))), rand_amount(),
                             RAW_W'($urandom_range(0, 255)), RAW_W'($urandom_range(0, 255)),
                             RAW_W'($urandom_range(0, 255)), RAW_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                end else if (pick < 6) begin
                    // Line following run with readings near the deadband.
                    add_beat(MODE_FOLLOW, rand_amount(), 8'h00, 8'h00, BUMP_OFF, BUMP_OFF,
                             1'b1);
                    repeat ($urandom_range(2, 6)) begin
                        ll_i = $urandom_range(0, 255);
                        lr_i = ll_i + int'($urandom_range(0, 24)) - 12;
                        lr_i = (lr_i < 0) ? 0 : ((lr_i > 255) ? 255 : lr_i);
                        add_beat(MODE_TICK, rand_amount(), RAW_W'(ll_i), RAW_W'(lr_i),
                                 rand_bump(), rand_bump(), ($urandom_range(0, 4) != 0));
                    end
                    if ($urandom_range(0, 1) == 0)
                        add_beat(MODE_STOP, rand_amount(), 8'h00, 8'h00, BUMP_OFF,
                                 BUMP_OFF, 1'b1);
                end else if (pick < 9) begin
                    // Bump avoidance run, following cleared first.
                    add_beat(MODE_STOP, rand_amount(), 8'h00, 8'h00, BUMP_OFF, BUMP_OFF,
                             1'b1);
                    add_beat(MODE_AVOID, rand_amount(), 8'h00, 8'h00, BUMP_OFF, BUMP_OFF,
                             1'b1);
                    repeat ($urandom_range(3, 7))
                        add_beat(MODE_TICK, rand_amount(), RAW_W'($urandom_range(0, 255)),
                                 RAW_W'($urandom_range(0, 255)), rand_bump(), rand_bump(),
                                 ($urandom_range(0, 3) != 0));
                end else begin
                    // Noise: any mode, any field values.
                    repeat (3)
                        add_beat(t_mode'(MODE_W'($urandom_range(0, 7))), rand_amount(),
                                 RAW_W'($urandom_range(0, 255)), RAW_W'($urandom_range(0, 255)),
                                 RAW_W'($urandom_range(0, 255)), RAW_W'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                end
                // Now and then the sender waits for every outstanding result.
                if ($urandom_range(0, 7) == 0)
                    add_sync();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(feed_done && drained))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (motor_cmds_due.size() != 0)
            note_mismatch("motor commands never produced", motor_cmds_due.size(), '0);
        $display("Covered %0d command beats, %0d motor command beats, %0d register writes,",
                 beats_sent, results_seen, cfg_writes);
        $display("with random gaps and stalls on both sides and drains between settings.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
